@@ hdl/tcw_pkg.sv @@
// shared types and constants for the text console writer
package tcw_pkg;

    localparam int COLUMNS = 100;
    localparam int ROWS    = 75;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam logic [7:0] CODE_NULL     = 8'd0;
    localparam logic [7:0] CODE_LINEFEED = 8'd10;
    localparam logic [7:0] CODE_RETURN   = 8'd13;
    localparam logic [7:0] CODE_SPACE    = 8'd32;

    // last cycle of the row move, which is also the first cell of the bottom row
    localparam logic [ADDR_W-1:0] MOVE_LAST = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_READ       = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_SET_CURSOR = 2'd3
    } tcw_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MOVE,
        ST_FILL
    } tcw_state_t;

    typedef struct packed {
        tcw_op_t    operation;
        logic [7:0] char_code;
        logic [6:0] row;
        logic [6:0] col;
    } tcw_cmd_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [6:0] cursor_row;
        logic [7:0] cell_data;
    } tcw_result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } tcw_mem_req_t;

    typedef struct packed {
        logic       done;
        logic       rd_ok;
        logic [6:0] cursor_col;
        logic [6:0] cursor_row;
    } tcw_status_t;

endpackage

@@ hdl/tcw_ram.sv @@
// screen cell memory: one write port, one registered read port
module tcw_ram (
    input  logic                 clk,
    input  tcw_pkg::tcw_mem_req_t req,
    output logic [7:0]           rdata
);
    import tcw_pkg::*;

    logic [7:0] mem [CELLS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tcw_ctrl.sv @@
// command sequencer: cursor, cell writes, clear and scroll sweeps
module tcw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tcw_pkg::tcw_cmd_t     cmd,
    input  logic [7:0]            rdata,
    output logic                  busy,
    output tcw_pkg::tcw_mem_req_t req,
    output tcw_pkg::tcw_status_t  status
);
    import tcw_pkg::*;

    tcw_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [6:0]        cx_reg, cx_next;
    logic [6:0]        cy_reg, cy_next;
    logic              done_reg, done_next;
    logic              rd_ok_reg, rd_ok_next;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;
    logic              at_bottom;
    logic              at_last_col;

    assign cur_addr    = ADDR_W'(32'(cy_reg) * COLUMNS + 32'(cx_reg));
    assign rd_addr     = ADDR_W'(32'(cmd.row) * COLUMNS + 32'(cmd.col));
    assign rd_in_range = (32'(cmd.row) < ROWS) && (32'(cmd.col) < COLUMNS);
    assign at_bottom   = 32'(cy_reg) >= ROWS - 1;
    assign at_last_col = 32'(cx_reg) + 1 >= COLUMNS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            done_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            done_reg  <= done_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        done_next  = 1'b0;
        rd_ok_next = 1'b0;
        req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (cmd.operation)
                        OP_PUT:
                        begin
                            priority if (cmd.char_code == CODE_NULL)
                            begin
                                cx_next = cx_reg;
                            end
                            else if (cmd.char_code == CODE_RETURN)
                            begin
                                cx_next = '0;
                            end
                            else if (cmd.char_code == CODE_LINEFEED)
                            begin
                                cx_next = '0;
                                if (at_bottom)
                                begin
                                    state_next = ST_MOVE;
                                    cnt_next   = '0;
                                end
                                else
                                begin
                                    cy_next = cy_reg + 7'd1;
                                end
                            end
                            else
                            begin
                                req.we    = 1'b1;
                                req.waddr = cur_addr;
                                req.wdata = cmd.char_code;
                                if (at_last_col)
                                begin
                                    cx_next = '0;
                                    if (at_bottom)
                                    begin
                                        state_next = ST_MOVE;
                                        cnt_next   = '0;
                                    end
                                    else
                                    begin
                                        cy_next = cy_reg + 7'd1;
                                    end
                                end
                                else
                                begin
                                    cx_next = cx_reg + 7'd1;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            req.re     = rd_in_range;
                            req.raddr  = rd_addr;
                            rd_ok_next = rd_in_range;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                            cnt_next   = '0;
                        end
                        OP_SET_CURSOR:
                        begin
                            cy_next = (32'(cmd.row) < ROWS) ? cmd.row : 7'(ROWS - 1);
                            cx_next = (32'(cmd.col) < COLUMNS) ? cmd.col : 7'(COLUMNS - 1);
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                req.we    = 1'b1;
                req.waddr = cnt_reg;
                req.wdata = CODE_NULL;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MOVE:
            begin
                // read one row ahead, write it back in the next cycle
                if (cnt_reg != MOVE_LAST)
                begin
                    req.re    = 1'b1;
                    req.raddr = ADDR_W'(32'(cnt_reg) + COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    req.we    = 1'b1;
                    req.waddr = cnt_reg - 1'b1;
                    req.wdata = rdata;
                end
                if (cnt_reg == MOVE_LAST)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                req.we    = 1'b1;
                req.waddr = cnt_reg;
                req.wdata = CODE_SPACE;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        endcase
    end

    assign busy              = (state_reg != ST_IDLE);
    assign status.done       = done_reg;
    assign status.rd_ok      = rd_ok_reg;
    assign status.cursor_col = cx_reg;
    assign status.cursor_row = cy_reg;

`ifndef NO_ASSERTIONS
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done_reg)
        else $error("accepted command produced no result");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cx_reg) < COLUMNS) && (32'(cy_reg) < ROWS))
        else $error("cursor outside the screen");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> (state_reg != ST_IDLE) || start)
        else $error("memory write without command or sweep");

    a_move_then_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE && cnt_reg == MOVE_LAST) |=>
        (state_reg == ST_FILL && cnt_reg == MOVE_LAST))
        else $error("row move did not hand over to bottom row fill");

    a_no_done_while_sweeping: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy)) |-> !done_reg)
        else $error("result strobe during a sweep");
`endif

endmodule

@@ hdl/text_console_writer.sv @@
// top level of the text console writer: sequencer plus screen memory
// latency: every accepted command gives its result strobe in the next cycle
// throughput: one command per cycle while busy is low; clears and scrolls raise busy
// a clear zeroes every cell; a scroll moves the rows up and fills the bottom row with spaces
// reset: cursor goes to 0,0 and busy stays high while memory is zeroed
// the result port has no back-pressure; done marks the one cycle of each result
module text_console_writer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tcw_pkg::tcw_cmd_t    cmd,
    output logic                done,
    output tcw_pkg::tcw_result_t result
);
    import tcw_pkg::*;

    tcw_mem_req_t mem_req;
    tcw_status_t  status;
    logic [7:0]   rdata;

    // sequencer owns the cursor and drives every memory access
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .rdata  (rdata),
        .busy   (busy),
        .req    (mem_req),
        .status (status)
    );

    // single screen store, read data registered inside
    tcw_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // result assembly: cell data only shows for an in-range read,
    // otherwise the transfer carries zero
    assign done              = status.done;
    assign result.cursor_col = status.cursor_col;
    assign result.cursor_row = status.cursor_row;
    assign result.cell_data  = status.rd_ok ? rdata : 8'd0;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the text console writer: directed table plus random traffic
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // watchdog: cycles with neither a command transfer nor a result strobe
    localparam int STALL_LIMIT  = 40000;
    // scrolls and clears each hold busy for a full store walk, so the random
    // traffic gets a fixed allowance of them to keep the run length sane
    localparam int SLOW_BUDGET  = 70;
    localparam int RANDOM_ITEMS = 1600;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        tcw_cmd_t    c;
        bit          typed;   // want holds a hand-written expectation
        tcw_result_t want;
    } stim_row_t;

    localparam tcw_result_t NO_WANT = '0;
    localparam int N_DIRECTED = 26;

    // directed table: extremes, every operation, and the special cases
    // (null byte, return, line feed, wrap, scroll both ways, clear, saturation,
    // out-of-range read)
    stim_row_t directed_rows [N_DIRECTED] = '{
        // fresh store reads zero everywhere, including far out of range
        '{'{OP_READ, 8'd0, 7'd0, 7'd0},             1'b1, '{7'd0, 7'd0, 8'd0}},
        '{'{OP_READ, 8'd0, 7'd74, 7'd99},           1'b1, '{7'd0, 7'd0, 8'd0}},
        '{'{OP_READ, 8'hFF, 7'd127, 7'd127},        1'b1, '{7'd0, 7'd0, 8'd0}},
        '{'{OP_PUT, 8'h41, 7'd0, 7'd0},             1'b1, '{7'd1, 7'd0, 8'd0}},
        // null byte leaves the cursor alone
        '{'{OP_PUT, CODE_NULL, 7'd127, 7'd127},     1'b1, '{7'd1, 7'd0, 8'd0}},
        '{'{OP_PUT, 8'hFF, 7'd0, 7'd0},             1'b0, NO_WANT},
        '{'{OP_PUT, CODE_RETURN, 7'd0, 7'd0},       1'b1, '{7'd0, 7'd0, 8'd0}},
        '{'{OP_PUT, CODE_LINEFEED, 7'd0, 7'd0},     1'b1, '{7'd0, 7'd1, 8'd0}},
        '{'{OP_READ, 8'd0, 7'd0, 7'd1},             1'b0, NO_WANT},
        // set cursor saturates both coordinates
        '{'{OP_SET_CURSOR, 8'd0, 7'd127, 7'd127},   1'b1, '{7'd99, 7'd74, 8'd0}},
        // last cell of the bottom row: the wrap scrolls
        '{'{OP_PUT, 8'h5A, 7'd0, 7'd0},             1'b0, NO_WANT},
        '{'{OP_READ, 8'd0, 7'd73, 7'd99},           1'b0, NO_WANT},
        '{'{OP_READ, 8'd0, 7'd74, 7'd0},            1'b0, NO_WANT},
        '{'{OP_SET_CURSOR, 8'd0, 7'd74, 7'd5},      1'b1, '{7'd5, 7'd74, 8'd0}},
        // line feed on the bottom row scrolls too
        '{'{OP_PUT, CODE_LINEFEED, 7'd0, 7'd0},     1'b0, NO_WANT},
        '{'{OP_SET_CURSOR, 8'd0, 7'd0, 7'd0},       1'b1, '{7'd0, 7'd0, 8'd0}},
        '{'{OP_PUT, 8'h80, 7'd0, 7'd0},             1'b0, NO_WANT},
        '{'{OP_READ, 8'd0, 7'd0, 7'd0},             1'b0, NO_WANT},
        // clear zeroes the store and keeps the cursor
        '{'{OP_CLEAR, 8'hFF, 7'd127, 7'd127},       1'b0, NO_WANT},
        '{'{OP_READ, 8'd0, 7'd0, 7'd0},             1'b0, NO_WANT},
        '{'{OP_SET_CURSOR, 8'd0, 7'd74, 7'd127},    1'b1, '{7'd99, 7'd74, 8'd0}},
        '{'{OP_SET_CURSOR, 8'd0, 7'd127, 7'd0},     1'b1, '{7'd0, 7'd74, 8'd0}},
        '{'{OP_PUT, 8'h7F, 7'd0, 7'd0},             1'b0, NO_WANT},
        '{'{OP_READ, 8'd0, 7'd74, 7'd0},            1'b0, NO_WANT},
        // wrap off the last column of an upper row just moves down
        '{'{OP_SET_CURSOR, 8'd0, 7'd0, 7'd99},      1'b1, '{7'd99, 7'd0, 8'd0}},
        '{'{OP_PUT, 8'h01, 7'd0, 7'd0},             1'b0, NO_WANT}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    tcw_cmd_t    cmd;
    logic        done;
    tcw_result_t result;

    text_console_writer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // shadow copy of the screen and cursor
    logic [7:0] screen [CELLS];
    int         cur_x;
    int         cur_y;

    tcw_result_t reply_q [$];
    int          errors;
    int          stall_cycles;
    int          slow_left;
    int          items_sent;
    int          no_idle_left;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // advance the cursor to the next line, scrolling on the bottom row
    function automatic void line_advance();
        if (cur_y >= ROWS - 1)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = CODE_SPACE;
        end
        else
            cur_y++;
        cur_x = 0;
    endfunction

    // apply one command to the shadow screen and give the expected reply
    function automatic tcw_result_t console_apply(input tcw_cmd_t c);
        tcw_result_t r;
        r = '0;
        case (c.operation)
            OP_PUT:
            begin
                if (c.char_code == CODE_RETURN)
                    cur_x = 0;
                else if (c.char_code == CODE_LINEFEED)
                    line_advance();
                else if (c.char_code != CODE_NULL)
                begin
                    screen[cur_y * COLUMNS + cur_x] = c.char_code;
                    cur_x++;
                    if (cur_x >= COLUMNS)
                        line_advance();
                end
            end
            OP_READ:
            begin
                if (int'(c.row) < ROWS && int'(c.col) < COLUMNS)
                    r.cell_data = screen[int'(c.row) * COLUMNS + int'(c.col)];
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = 8'd0;
            end
            default:
            begin
                cur_y = (int'(c.row) < ROWS) ? int'(c.row) : ROWS - 1;
                cur_x = (int'(c.col) < COLUMNS) ? int'(c.col) : COLUMNS - 1;
            end
        endcase
        r.cursor_col = 7'(cur_x);
        r.cursor_row = 7'(cur_y);
        return r;
    endfunction

    // true when the command makes the block walk the whole store
    function automatic bit walks_store(input tcw_cmd_t c);
        if (c.operation == OP_CLEAR)
            return 1'b1;
        if (c.operation != OP_PUT || cur_y != ROWS - 1)
            return 1'b0;
        if (c.char_code == CODE_LINEFEED)
            return 1'b1;
        return c.char_code != CODE_NULL && c.char_code != CODE_RETURN && cur_x == COLUMNS - 1;
    endfunction

    // one command transfer: random gap, then hold start until busy drops
    task automatic send_cmd(input tcw_cmd_t c, input bit typed, input tcw_result_t want);
        int          gap;
        tcw_result_t predicted;
        if (no_idle_left > 0)
        begin
            gap = 0;
            no_idle_left--;
        end
        else
        begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 99) == 0)
                no_idle_left = $urandom_range(20, 150);
        end
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        // transfer happens at the first rising edge with busy low
        do
            @(posedge clk);
        while (busy);
        predicted = console_apply(c);
        reply_q.push_back(typed ? want : predicted);
    endtask

    // random-side wrapper: keeps store walks within budget, counts real items
    task automatic issue_random(input tcw_cmd_t c);
        if (walks_store(c))
        begin
            if (slow_left > 0)
                slow_left--;
            else
            begin
                c.operation = OP_SET_CURSOR;
                c.row = 7'($urandom_range(0, ROWS - 2));
                c.col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end
        if (!(c.operation == OP_PUT && c.char_code == CODE_NULL))
            items_sent++;
        send_cmd(c, 1'b0, NO_WANT);
    endtask

    // mostly printable text, with control bytes, high bytes and nulls mixed in
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 8'($urandom_range(32, 126));
        else if (pick < 80)
            return 8'($urandom_range(1, 255));
        else if (pick < 88)
            return CODE_LINEFEED;
        else if (pick < 95)
            return CODE_RETURN;
        return CODE_NULL;
    endfunction

    task automatic run_random_traffic();
        tcw_cmd_t c;
        int       kind;
        int       len;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // a run of text from a fresh cursor position, the bottom row now and then
                c.operation = OP_SET_CURSOR;
                c.char_code = 8'($urandom_range(0, 255));
                c.row = ($urandom_range(0, 9) == 0) ? 7'(ROWS - 1)
                                                    : 7'($urandom_range(0, ROWS - 2));
                c.col = 7'($urandom_range(0, COLUMNS - 1));
                issue_random(c);
                len = $urandom_range(1, 40);
                repeat (len)
                begin
                    c.operation = OP_PUT;
                    c.char_code = text_byte();
                    c.row = 7'($urandom_range(0, 127));
                    c.col = 7'($urandom_range(0, 127));
                    issue_random(c);
                end
            end
            else if (kind < 70)
            begin
                // read back around the cursor, sometimes anywhere or out of range
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    c.operation = OP_READ;
                    c.char_code = 8'($urandom_range(0, 255));
                    case ($urandom_range(0, 3))
                        0: c.row = 7'(cur_y);
                        1: c.row = 7'((cur_y > 0) ? cur_y - 1 : 0);
                        2: c.row = 7'($urandom_range(0, ROWS - 1));
                        default: c.row = 7'($urandom_range(0, 127));
                    endcase
                    c.col = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(0, COLUMNS - 1));
                    issue_random(c);
                end
            end
            else
            begin
                // noise: any field value, clears kept rare
                c.operation = tcw_op_t'($urandom_range(0, 3));
                if (c.operation == OP_CLEAR && kind < 97)
                    c.operation = OP_PUT;
                c.char_code = 8'($urandom_range(0, 255));
                c.row = 7'($urandom_range(0, 127));
                c.col = 7'($urandom_range(0, 127));
                issue_random(c);
            end
        end
    endtask

    // result checker: every strobe must match the oldest expectation
    always @(posedge clk)
    begin
        if (done)
        begin
            if (reply_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: col=%0d row=%0d data=%02h",
                             result.cursor_col, result.cursor_row, result.cell_data);
            end
            else
            begin
                tcw_result_t exp_r;
                exp_r = reply_q.pop_front();
                if (result.cursor_col !== exp_r.cursor_col ||
                    result.cursor_row !== exp_r.cursor_row ||
                    result.cell_data  !== exp_r.cell_data)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result mismatch: exp col=%0d row=%0d data=%02h, got col=%0d row=%0d data=%02h",
                                 exp_r.cursor_col, exp_r.cursor_row, exp_r.cell_data,
                                 result.cursor_col, result.cursor_row, result.cell_data);
                end
            end
        end
    end

    // watchdog: no transfer and no result for too long ends the run
    always @(posedge clk)
    begin
        if (done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        stall_cycles = 0;
        slow_left    = SLOW_BUDGET;
        items_sent   = 0;
        no_idle_left = 0;
        cur_x        = 0;
        cur_y        = 0;
        for (int i = 0; i < CELLS; i++)
            screen[i] = 8'd0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the block clears its store after reset; send_cmd waits on busy
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

        run_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        // drain, then give stray strobes a chance to show up
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (reply_q.size() != 0)
            errors++;

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
